// ===== sv/ascii_hex_frame_receiver_defines.svh =====
// Assertion macros for the ASCII hex frame receiver checker.
// Bodies expect signals named clk and rst_n in the scope of use.
`ifndef ASCII_HEX_FRAME_RECEIVER_DEFINES_SVH
`define ASCII_HEX_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define AHFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define AHFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that holds while reset is applied.
`define AHFR_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/ahfr_pkg.sv =====
// Package for the ASCII hex frame receiver: beat and result types,
// framing byte codes and byte positions. No dependencies.
package ahfr_pkg;

    localparam logic [7:0] START_BYTE = 8'h3A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    localparam logic [4:0] FIRST_DIGIT_POS = 5'd1;
    localparam logic [4:0] LAST_DIGIT_POS  = 5'd14;
    localparam logic [4:0] CR_POS          = 5'd15;
    localparam logic [4:0] LF_POS          = 5'd16;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ADDR_MISS = 2'd1,
        STATUS_LRC_MISS  = 2'd2
    } ahfr_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } ahfr_rx_t;

    typedef struct packed {
        logic [7:0]   frame_address;
        logic [7:0]   frame_command;
        logic [15:0]  frame_content;
        logic [15:0]  frame_data;
        ahfr_status_t frame_status;
    } ahfr_result_t;

    // Byte held in the input register, as seen by the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } ahfr_beat_t;

endpackage

// ===== sv/ahfr_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Used for the receive byte and frame result channels.
interface ahfr_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ahfr_in_stage.sv =====
// Input register for received bytes.
// Depends on ahfr_pkg and ahfr_stream_if.
module ahfr_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    ahfr_stream_if.sink         rx,
    input  logic                take,
    output ahfr_pkg::ahfr_beat_t beat
);
    import ahfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Refill whenever the held byte leaves or the register is empty.
    assign rx.ready   = !valid_reg || take;
    assign valid_next = rx.ready ? rx.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.data.rx_byte;
        end
    end

    assign beat.valid   = valid_reg;
    assign beat.rx_byte = byte_reg;
endmodule

// ===== sv/ahfr_parser.sv =====
// Frame parser: position tracking, hex decode, payload shift, LRC and
// address check, station address register. Depends on ahfr_pkg.
module ahfr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  ahfr_pkg::ahfr_beat_t  beat,
    input  logic                  can_load,
    output logic                  take,
    output logic                  load,
    output ahfr_pkg::ahfr_result_t result
);
    import ahfr_pkg::*;

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [55:0] shift_reg;
    logic [55:0] shift_next;
    logic [3:0]  nibble_reg;
    logic [3:0]  nibble_next;
    logic [7:0]  station_address_reg;

    logic [7:0]  c;
    logic        digit_ok;
    logic [3:0]  digit;
    logic        frame_done;
    logic [7:0]  sum;

    // Uppercase hex digits only.
    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            digit = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            digit = 4'(c - 8'h37);
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign c = beat.rx_byte;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        nibble_next   = nibble_reg;
        frame_done    = 1'b0;
        if (c == START_BYTE)
        begin
            // A start byte always reopens the frame.
            in_frame_next = 1'b1;
            pos_next      = FIRST_DIGIT_POS;
            shift_next    = '0;
            nibble_next   = '0;
        end
        else if (in_frame_reg)
        begin
            if (pos_reg inside {[FIRST_DIGIT_POS:LAST_DIGIT_POS]})
            begin
                if (!digit_ok)
                begin
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                end
                else
                begin
                    if (pos_reg[0])
                    begin
                        nibble_next = digit;
                    end
                    else
                    begin
                        shift_next = {shift_reg[47:0], nibble_reg, digit};
                    end
                    pos_next = pos_reg + 5'd1;
                end
            end
            else if (pos_reg == CR_POS && c == CR_BYTE)
            begin
                pos_next = LF_POS;
            end
            else
            begin
                // Complete on LF; drop on anything else.
                frame_done    = (pos_reg == LF_POS) && (c == LF_BYTE);
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
        end
    end

    assign take = beat.valid && (!frame_done || can_load);
    assign load = beat.valid && frame_done && can_load;

    // Frame is good when payload sum plus LRC wraps to zero.
    assign sum = shift_reg[55:48] + shift_reg[47:40] + shift_reg[39:32]
               + shift_reg[31:24] + shift_reg[23:16] + shift_reg[15:8];

    always_comb
    begin
        result.frame_address = shift_reg[55:48];
        result.frame_command = shift_reg[47:40];
        result.frame_content = shift_reg[39:24];
        result.frame_data    = shift_reg[23:8];
        if (8'(sum + shift_reg[7:0]) != 8'd0)
        begin
            result.frame_status = STATUS_LRC_MISS;
        end
        else if (shift_reg[55:48] != station_address_reg)
        begin
            result.frame_status = STATUS_ADDR_MISS;
        end
        else
        begin
            result.frame_status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg        <= 1'b0;
            pos_reg             <= '0;
            shift_reg           <= '0;
            nibble_reg          <= '0;
            station_address_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
                shift_reg    <= shift_next;
                nibble_reg   <= nibble_next;
            end
            if (cfg_wr_en)
            begin
                station_address_reg <= cfg_wr_data;
            end
        end
    end
endmodule

// ===== sv/ahfr_out_stage.sv =====
// Result register for decoded frames.
// Depends on ahfr_pkg and ahfr_stream_if.
module ahfr_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  ahfr_pkg::ahfr_result_t result,
    output logic                   can_load,
    ahfr_stream_if.source          frame
);
    import ahfr_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    ahfr_result_t result_reg;

    assign can_load   = !valid_reg || frame.ready;
    assign valid_next = load ? 1'b1 : (frame.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign frame.valid = valid_reg;
    assign frame.data  = result_reg;
endmodule

// ===== sv/ascii_hex_frame_receiver.sv =====
// Channel  Dir  Payload                                        Beat when
// rx       in   rx_byte (8b)                                   valid && ready
// frame    out  address, command, content, data, status        valid && ready
// cfg      in   cfg_wr_data = station_address (8b)             cfg_wr_en
//
// One byte per cycle sustained while results drain: input register, one pass
// of decode logic, result register. A byte reaches the parser in the cycle
// after its beat; a result shows in the cycle after the closing LF is parsed.
// Asynchronous active-low reset empties both registers and closes any frame.
// A stalled result holds the LF byte in the input register; no further bytes
// are taken while the result waits.
// Top level of the ASCII hex frame receiver; depends on ahfr_pkg,
// ahfr_stream_if, ahfr_in_stage, ahfr_parser and ahfr_out_stage.
module ascii_hex_frame_receiver (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    ahfr_stream_if.sink   rx,
    ahfr_stream_if.source frame
);
    import ahfr_pkg::*;

    ahfr_beat_t   beat;
    ahfr_result_t result;
    logic         take;
    logic         load;
    logic         can_load;

    ahfr_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .beat  (beat)
    );

    ahfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat        (beat),
        .can_load    (can_load),
        .take        (take),
        .load        (load),
        .result      (result)
    );

    ahfr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .can_load (can_load),
        .frame    (frame)
    );
endmodule

// ===== sv/ahfr_checker.sv =====
// Port-level checker for the ASCII hex frame receiver, bound to the top.
// Depends on ahfr_pkg and ascii_hex_frame_receiver_defines.svh.
`include "ascii_hex_frame_receiver_defines.svh"

module ahfr_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rx_ready,
    input logic                   frame_valid,
    input logic                   frame_ready,
    input ahfr_pkg::ahfr_result_t frame_data
);
    import ahfr_pkg::*;

    // Hold a stalled result.
    `AHFR_ASSERT_NXT(a_frame_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_data), "stalled frame result changed")

    // Drain free on the output side: the input must take bytes.
    `AHFR_ASSERT_IMP(a_rx_ready_free, !frame_valid || frame_ready, rx_ready, "rx stalled while frame side is free")

    // Reset empties the result register.
    `AHFR_ASSERT_RST(a_reset_empty, !frame_valid, "frame valid during reset")
endmodule

bind ascii_hex_frame_receiver ahfr_checker u_ahfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_ready    (rx.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_data  (frame.data)
);
